// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== src/brq_pkg.sv =====
// Shared types and constants of the bounded ring queue.
`timescale 1ns / 1ps
package brq_pkg;

    localparam int CNT_W = 5;
    localparam int CMD_W = 2;

    localparam logic [CMD_W-1:0] CMD_APPEND   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP_HEAD = 2'd1;
    localparam logic [CMD_W-1:0] CMD_POP_TAIL = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR    = 2'd3;

    localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;

    // Controller to datapath strobes
    typedef struct packed {
        logic accept;    // latch the input beat
        logic exec;      // run the command on the queue
        logic load_out;  // move the result into the output register
        logic cfg_wr;    // take the capacity write
    } brq_ctrl_t;

endpackage

// ===== src/brq_ctrl.sv =====
// Command sequencer: accept, execute, write back into the output register.
`timescale 1ns / 1ps
module brq_ctrl
    import brq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    output brq_ctrl_t ctrl
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_WB   = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       load;

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    // Output register is free when empty or being drained this cycle
    assign load = (state_reg == ST_WB) && (!out_valid_reg || out_ready);

    assign ctrl.accept   = in_valid && in_ready;
    assign ctrl.exec     = (state_reg == ST_EXEC);
    assign ctrl.load_out = load;
    assign ctrl.cfg_wr   = cfg_valid && cfg_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_WB;
            end
            ST_WB:
            begin
                if (load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== src/brq_datapath.sv =====
// Queue storage, pointers, held count, capacity and result register.
`timescale 1ns / 1ps
module brq_datapath
    import brq_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int VALUE_BITS = 32
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  brq_ctrl_t                    ctrl,
    input  logic [CMD_W-1:0]             command,
    input  logic signed [VALUE_BITS-1:0] value,
    input  logic [CNT_W-1:0]             cfg_data,
    output logic                         ok,
    output logic [CNT_W-1:0]             count,
    output logic signed [VALUE_BITS-1:0] popped_value
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int AW    = (IDX_W + 1 > CNT_W) ? IDX_W + 1 : CNT_W;

    logic [VALUE_BITS-1:0] slot_mem [DEPTH];

    logic [CMD_W-1:0]      cmd_reg;
    logic [VALUE_BITS-1:0] value_reg;
    logic [CNT_W-1:0]      capacity_reg;
    logic [IDX_W-1:0]      head_reg;
    logic [IDX_W-1:0]      tail_reg;
    logic [CNT_W-1:0]      held_reg;
    logic [VALUE_BITS-1:0] last_popped_reg;
    logic                  ok_reg;
    logic                  pop_hit_reg;
    logic [VALUE_BITS-1:0] rd_data_reg;
    logic                  ok_out_reg;
    logic [CNT_W-1:0]      count_out_reg;
    logic [VALUE_BITS-1:0] popped_out_reg;

    logic [CNT_W-1:0]      cap_eff;
    logic [AW-1:0]         head_inc;
    logic [AW-1:0]         tail_inc;
    logic [IDX_W-1:0]      head_adv;
    logic [IDX_W-1:0]      tail_adv;
    logic [IDX_W-1:0]      tail_prev;
    logic [IDX_W-1:0]      rd_addr;
    logic                  can_push;
    logic                  can_pop;
    logic                  mem_we;

    // Capacity above the storage depth saturates
    assign cap_eff = (AW'(capacity_reg) > AW'(DEPTH)) ? CNT_W'(DEPTH) : capacity_reg;

    assign head_inc  = AW'(head_reg) + AW'(1);
    assign tail_inc  = AW'(tail_reg) + AW'(1);
    assign head_adv  = (head_inc >= AW'(cap_eff)) ? '0 : IDX_W'(head_inc);
    assign tail_adv  = (tail_inc >= AW'(cap_eff)) ? '0 : IDX_W'(tail_inc);
    assign tail_prev = (tail_reg == '0) ? IDX_W'(AW'(cap_eff) - AW'(1))
                                        : tail_reg - IDX_W'(1);

    assign can_push = (held_reg < cap_eff);
    assign can_pop  = (held_reg != '0);
    assign mem_we   = ctrl.exec && (cmd_reg == CMD_APPEND) && can_push;
    assign rd_addr  = (cmd_reg == CMD_POP_TAIL) ? tail_prev : head_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[tail_reg] <= value_reg;
        end
    end

    // Capture the popped word at execute; hold it through a stalled write back
    always_ff @(posedge clk)
    begin
        if (ctrl.exec)
        begin
            rd_data_reg <= slot_mem[rd_addr];
        end
    end

    // Input beat and result payload
    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            cmd_reg   <= command;
            value_reg <= value;
        end
        if (ctrl.load_out)
        begin
            ok_out_reg     <= ok_reg;
            count_out_reg  <= held_reg;
            popped_out_reg <= pop_hit_reg ? rd_data_reg : last_popped_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg    <= CAP_RESET;
            head_reg        <= '0;
            tail_reg        <= '0;
            held_reg        <= '0;
            last_popped_reg <= '1;
            ok_reg          <= 1'b0;
            pop_hit_reg     <= 1'b0;
        end
        else
        begin
            if (ctrl.cfg_wr)
            begin
                capacity_reg <= cfg_data;
                head_reg     <= '0;
                tail_reg     <= '0;
                held_reg     <= '0;
            end
            if (ctrl.exec)
            begin
                pop_hit_reg <= 1'b0;
                case (cmd_reg)
                    CMD_APPEND:
                    begin
                        ok_reg <= can_push;
                        if (can_push)
                        begin
                            tail_reg <= tail_adv;
                            held_reg <= held_reg + CNT_W'(1);
                        end
                    end
                    CMD_POP_HEAD:
                    begin
                        ok_reg      <= can_pop;
                        pop_hit_reg <= can_pop;
                        if (can_pop)
                        begin
                            head_reg <= head_adv;
                            held_reg <= held_reg - CNT_W'(1);
                        end
                    end
                    CMD_POP_TAIL:
                    begin
                        ok_reg      <= can_pop;
                        pop_hit_reg <= can_pop;
                        if (can_pop)
                        begin
                            tail_reg <= tail_prev;
                            held_reg <= held_reg - CNT_W'(1);
                        end
                    end
                    default:
                    begin
                        ok_reg   <= 1'b1;
                        head_reg <= '0;
                        tail_reg <= '0;
                        held_reg <= '0;
                    end
                endcase
            end
            // Commit the popped word once the read data lands
            if (ctrl.load_out && pop_hit_reg)
            begin
                last_popped_reg <= rd_data_reg;
            end
        end
    end

    assign ok           = ok_out_reg;
    assign count        = count_out_reg;
    assign popped_value = popped_out_reg;

endmodule

// ===== src/bounded_ring_queue_two_end_pop.sv =====
// Top level of the bounded ring queue with pop from head or tail.
//
//   channel | signals                            | direction
//   --------+------------------------------------+----------
//   cmd in  | in_valid in_ready command value    | in
//   result  | out_valid out_ready ok count       | out
//           | popped_value                       |
//   config  | cfg_valid cfg_ready cfg_data       | in
//
// Each command passes through accept, execute (one slot memory access and
// pointer update) and write back into the output register.
// A stalled result holds the sequencer in write back; the result register
// frees as soon as out_ready drains it.
// Reset clears pointers and count, sets capacity to 16 at once; slots are not cleared.
// Capacity writes are taken while the sequencer idles and empty the queue.
`timescale 1ns / 1ps
module bounded_ring_queue_two_end_pop
    import brq_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int VALUE_BITS = 32
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [CMD_W-1:0]             command,
    input  logic signed [VALUE_BITS-1:0] value,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         ok,
    output logic [CNT_W-1:0]             count,
    output logic signed [VALUE_BITS-1:0] popped_value,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [CNT_W-1:0]             cfg_data
);

    brq_ctrl_t ctrl;

    brq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .ctrl      (ctrl)
    );

    brq_datapath #(
        .DEPTH      (DEPTH),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .command      (command),
        .value        (value),
        .cfg_data     (cfg_data),
        .ok           (ok),
        .count        (count),
        .popped_value (popped_value)
    );

endmodule

// ===== src/brq_checker.sv =====
// Port-level checks for the bounded ring queue, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module brq_checker
    import brq_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int VALUE_BITS = 32
)
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic [CMD_W-1:0]      command,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic                  ok,
    input logic [CNT_W-1:0]      count,
    input logic [VALUE_BITS-1:0] popped_value
);

    logic [CMD_W-1:0] last_cmd_reg;
    logic [CMD_W-1:0] res_cmd_reg;

    // Track the command of the beat in flight and of the result on show
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_cmd_reg <= CMD_CLEAR;
            res_cmd_reg  <= CMD_CLEAR;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                last_cmd_reg <= command;
            end
            // The result register reloads only while free or draining
            if (!out_valid || out_ready)
            begin
                res_cmd_reg <= last_cmd_reg;
            end
        end
    end

    `ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)
    `ASSERT_SAME(a_count_bound, out_valid, 32'(count) <= DEPTH)
    `ASSERT_SAME(a_clear_empties, out_valid && (res_cmd_reg == CMD_CLEAR), ok && (count == '0))
    `ASSERT_SAME(a_pop_fail_empty, out_valid && !ok && (res_cmd_reg != CMD_APPEND), count == '0)
    `ASSERT_NEXT(a_result_holds, out_valid && !out_ready, out_valid && $stable(ok) && $stable(count) && $stable(popped_value))

endmodule

bind bounded_ring_queue_two_end_pop brq_checker #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS)
) u_brq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .command      (command),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .ok           (ok),
    .count        (count),
    .popped_value (popped_value)
);

// ===== tb/bounded_ring_queue_two_end_pop_test.sv =====
// Self-checking bench for the bounded ring queue with pop from either end.
`timescale 1ns / 1ps

class ring_queue_tracker;
    typedef struct packed {
        logic        ok;
        logic [4:0]  count;
        logic [31:0] popped;
    } queue_result_t;

    logic [31:0]   slots [16];
    int unsigned   head;
    int unsigned   tail;
    int unsigned   held;
    logic [31:0]   last_popped;
    logic [4:0]    capacity;
    queue_result_t expected_results [$];
    int            errors;

    function new();
        head        = 0;
        tail        = 0;
        held        = 0;
        last_popped = '1;
        capacity    = brq_pkg::CAP_RESET;
        errors      = 0;
    endfunction

    function int pending();
        return expected_results.size();
    endfunction

    // A capacity write empties the queue but keeps the last popped word.
    function void load_capacity(logic [4:0] cap);
        capacity = cap;
        head     = 0;
        tail     = 0;
        held     = 0;
    endfunction

    function void note_command(logic [1:0] cmd, logic [31:0] word);
        int unsigned   cap;
        queue_result_t res;
        cap    = (capacity > 16) ? 16 : capacity;
        res.ok = 1'b0;
        case (cmd)
            brq_pkg::CMD_APPEND:
                if (held < cap)
                begin
                    slots[tail] = word;
                    tail        = (tail + 1 >= cap) ? 0 : tail + 1;
                    held++;
                    res.ok = 1'b1;
                end
            brq_pkg::CMD_POP_HEAD:
                if (held > 0)
                begin
                    last_popped = slots[head];
                    head        = (head + 1 >= cap) ? 0 : head + 1;
                    held--;
                    res.ok = 1'b1;
                end
            brq_pkg::CMD_POP_TAIL:
                if (held > 0)
                begin
                    tail        = (tail == 0) ? cap - 1 : tail - 1;
                    last_popped = slots[tail];
                    held--;
                    res.ok = 1'b1;
                end
            default:
            begin
                head   = 0;
                tail   = 0;
                held   = 0;
                res.ok = 1'b1;
            end
        endcase
        res.count  = 5'(held);
        res.popped = last_popped;
        expected_results.push_back(res);
    endfunction

    task report_mismatch(string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    task check_result(logic ok, logic [4:0] count, logic [31:0] popped);
        queue_result_t want;
        if (expected_results.size() == 0)
        begin
            report_mismatch($sformatf("result beat with none pending: ok=%0d count=%0d",
                                      ok, count));
            return;
        end
        want = expected_results.pop_front();
        if (ok !== want.ok)
            report_mismatch($sformatf("ok %0d, want %0d", ok, want.ok));
        if (count !== want.count)
            report_mismatch($sformatf("count %0d, want %0d", count, want.count));
        if (popped !== want.popped)
            report_mismatch($sformatf("popped_value %h, want %h", popped, want.popped));
    endtask
endclass

module bounded_ring_queue_two_end_pop_test;
    import brq_pkg::*;

    localparam int WORD_W      = 32;
    localparam int IDLE_PCT    = 34;
    localparam int STALL_LIMIT = 600;
    localparam int PHASE_ITEMS = 130;

    logic                     clk          = 1'b0;
    logic                     rst_n        = 1'b0;
    logic                     in_valid     = 1'b0;
    logic                     in_ready;
    logic [CMD_W-1:0]         command      = CMD_APPEND;
    logic signed [WORD_W-1:0] value        = '0;
    logic                     out_valid;
    logic                     out_ready    = 1'b0;
    logic                     ok;
    logic [CNT_W-1:0]         count;
    logic signed [WORD_W-1:0] popped_value;
    logic                     cfg_valid    = 1'b0;
    logic                     cfg_ready;
    logic [CNT_W-1:0]         cfg_data     = '0;

    ring_queue_tracker tracker;
    bit                calm           = 1'b0;
    int                stalled_cycles = 0;

    bounded_ring_queue_two_end_pop #(
        .DEPTH      (16),
        .VALUE_BITS (WORD_W)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .command      (command),
        .value        (value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .ok           (ok),
        .count        (count),
        .popped_value (popped_value),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            tracker.check_result(ok, count, popped_value);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            stalled_cycles <= 0;
        else
        begin
            stalled_cycles <= stalled_cycles + 1;
            if (stalled_cycles >= STALL_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    task automatic send_command(logic [CMD_W-1:0] cmd, logic [WORD_W-1:0] word);
        in_valid <= 1'b1;
        command  <= cmd;
        value    <= word;
        do @(posedge clk); while (!in_ready);
        tracker.note_command(cmd, word);
        if (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
        end
    endtask

    // Hold off the command channel until every pending result beat is back.
    task automatic drain_results();
        if (in_valid)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        while (tracker.pending() > 0)
            @(posedge clk);
    endtask

    task automatic write_capacity(logic [CNT_W-1:0] cap);
        drain_results();
        // let the sequencer fall back to idle
        repeat (6) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= cap;
        do @(posedge clk); while (!cfg_ready);
        tracker.load_capacity(cap);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [WORD_W-1:0] random_word();
        case ($urandom_range(9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return '1;
            3:       return '0;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [CMD_W-1:0] random_command(int append_pct);
        int roll;
        roll = $urandom_range(99);
        if (roll < 1)
            return CMD_CLEAR;
        if (roll < 1 + append_pct)
            return CMD_APPEND;
        return $urandom_range(1) ? CMD_POP_HEAD : CMD_POP_TAIL;
    endfunction

    initial
    begin
        logic [CNT_W-1:0] phase_caps [11];
        int               biases [3];
        tracker    = new();
        phase_caps = '{5'd16, 5'd1, 5'd2, 5'd31, 5'd5, 5'd0, 5'd17, 5'd3, 5'd8, 5'd16, 5'd4};
        biases     = '{75, 50, 30};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // empty pops at reset, word extremes, both pop ends, clear
        send_command(CMD_POP_HEAD, random_word());
        send_command(CMD_POP_TAIL, random_word());
        send_command(CMD_APPEND, 32'h7FFF_FFFF);
        send_command(CMD_APPEND, 32'h8000_0000);
        send_command(CMD_APPEND, '0);
        send_command(CMD_APPEND, '1);
        send_command(CMD_POP_HEAD, random_word());
        send_command(CMD_POP_TAIL, random_word());
        send_command(CMD_CLEAR, random_word());
        send_command(CMD_POP_HEAD, random_word());
        send_command(CMD_APPEND, 32'h5A5A_A5A5);
        send_command(CMD_POP_TAIL, random_word());

        // full queue at a small capacity
        write_capacity(5'd2);
        send_command(CMD_APPEND, 32'h1234_5678);
        send_command(CMD_APPEND, 32'hCAFE_0001);
        send_command(CMD_APPEND, 32'h0BAD_0BAD);
        send_command(CMD_POP_TAIL, random_word());
        send_command(CMD_POP_HEAD, random_word());
        send_command(CMD_POP_HEAD, random_word());

        // zero capacity holds nothing
        write_capacity(5'd0);
        send_command(CMD_APPEND, random_word());
        send_command(CMD_POP_TAIL, random_word());
        send_command(CMD_CLEAR, random_word());

        // capacity beyond depth saturates
        write_capacity(5'd31);
        send_command(CMD_APPEND, random_word());
        send_command(CMD_POP_HEAD, random_word());

        foreach (phase_caps[p])
        begin
            write_capacity(phase_caps[p]);
            calm = (p == 3);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (i == PHASE_ITEMS / 2)
                    drain_results();
                send_command(random_command(biases[p % 3]), random_word());
            end
            calm = 1'b0;
        end

        drain_results();
        repeat (10) @(posedge clk);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
